// ===== rtl/lidar_scan_packet_parser_defines.svh =====
// ----------------------------------------------------------------------------
// lidar scan packet parser assertion macros
// shared concurrent check forms, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_PACKET_PARSER_DEFINES_SVH
`define LIDAR_SCAN_PACKET_PARSER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define LSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lidar scan packet parser: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define LSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lidar scan packet parser: next-cycle check failed");

`endif

// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// constants, codes and types shared by the lidar scan packet parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int PACKET_BYTES = 22;
    localparam int ANGLE_COUNT  = 360;

    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam logic [7:0] INDEX_LOW  = 8'hA0;
    localparam logic [7:0] INDEX_HIGH = 8'hF9;

    // byte positions inside a packet
    localparam logic [4:0] POS_INDEX    = 5'd1;
    localparam logic [4:0] POS_SPEED_HI = 5'd3;
    localparam logic [4:0] POS_DIST0_HI = 5'd5;
    localparam logic [4:0] POS_CKSUM_LO = 5'd20;

    localparam int ACC_W   = 26;
    localparam int SUM_W   = 15;
    localparam int WORD_W  = 16;
    localparam int SLOT_W  = 9;
    localparam int DIST_W  = 14;
    localparam int SPEED_W = 10;

    localparam logic [2:0] ST_ABSORBED  = 3'd0;
    localparam logic [2:0] ST_STORED    = 3'd1;
    localparam logic [2:0] ST_BAD_CKSUM = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_READ_DATA = 3'd4;

    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_CLEAR,
        ALU_SHADD,
        ALU_FOLD
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [WORD_W-1:0]   operand;
    } t_alu_ctl;

endpackage

`default_nettype wire

// ===== rtl/lsp_ram.sv =====
// ----------------------------------------------------------------------------
// lsp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 360,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lsp_cksum.sv =====
// ----------------------------------------------------------------------------
// lsp_cksum
// shared shift-add accumulator for the packet checksum, with end-around fold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_cksum (
    input  wire logic                    i_clk,
    input  wire lsp_pkg::t_alu_ctl       i_ctl,
    output logic [lsp_pkg::SUM_W-1:0]    o_sum
);

    logic [lsp_pkg::ACC_W-1:0] r_acc;
    logic [lsp_pkg::ACC_W-1:0] n_acc;
    logic [lsp_pkg::WORD_W-1:0] fold;

    // low 15 bits plus everything above them
    assign fold = lsp_pkg::WORD_W'(r_acc[lsp_pkg::SUM_W-1:0])
                + lsp_pkg::WORD_W'(r_acc[lsp_pkg::ACC_W-1:lsp_pkg::SUM_W]);

    always_comb begin
        n_acc = r_acc;
        unique case (i_ctl.op)
            lsp_pkg::ALU_HOLD:  n_acc = r_acc;
            lsp_pkg::ALU_CLEAR: n_acc = '0;
            lsp_pkg::ALU_SHADD: n_acc = (r_acc << 1) + lsp_pkg::ACC_W'(i_ctl.operand);
            lsp_pkg::ALU_FOLD:  n_acc = lsp_pkg::ACC_W'(fold[lsp_pkg::SUM_W-1:0]);
            default:            n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_sum = r_acc[lsp_pkg::SUM_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/lidar_scan_packet_parser.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser
// scan packet decoder with distance table and read-at-angle command
// ----------------------------------------------------------------------------
// Each input word is either a received serial byte (tuser low) or a read at an
// angle (tuser high), and each gives exactly one result word. After reset the
// distance table is swept to zero, one entry a cycle, so the input stays not
// ready until the sweep is done. Afterwards an ordinary byte passes through
// execute and output before the next word can be taken, a read also passes
// through the registered table read, and the last byte of a packet goes on
// to fold the checksum held in the shared shift-add accumulator, to check
// index and checksum, and, when it is stored, to a table write port step
// for each of the four readings. A result waiting at the output stalls the
// parser only when a second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_scan_packet_parser #(
    parameter int ANGLE_COUNT = lsp_pkg::ANGLE_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // rx_byte [7:0], angle [16:8], zero fill
    input  wire logic        s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // distance [13:0], speed [23:14]
    output logic      [2:0]  m_axis_tuser    // status
);

    localparam int AW = $clog2(ANGLE_COUNT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_FOLD  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    // control
    t_state                       r_state,      n_state;
    logic                         r_collecting, n_collecting;
    logic [4:0]                   r_byte_count, n_byte_count;
    logic [AW-1:0]                r_clr_addr,   n_clr_addr;
    logic [lsp_pkg::SPEED_W-1:0]  r_speed,      n_speed;
    logic                         r_out_valid,  n_out_valid;

    // payload
    logic                         r_cmd,        n_cmd;
    logic [7:0]                   r_rx,         n_rx;
    logic [8:0]                   r_angle,      n_angle;
    logic [7:0]                   r_lo,         n_lo;
    logic [7:0]                   r_index,      n_index;
    logic [lsp_pkg::SPEED_W-1:0]  r_speed_new,  n_speed_new;
    logic [lsp_pkg::DIST_W:0]     r_dist [4];
    logic [lsp_pkg::DIST_W:0]     n_dist [4];
    logic [lsp_pkg::WORD_W-1:0]   r_given,      n_given;
    logic [1:0]                   r_wcnt,       n_wcnt;
    logic [2:0]                   r_res_status, n_res_status;
    logic [lsp_pkg::DIST_W-1:0]   r_res_dist,   n_res_dist;
    logic [2:0]                   r_out_status, n_out_status;
    logic [lsp_pkg::DIST_W-1:0]   r_out_dist,   n_out_dist;
    logic [lsp_pkg::SPEED_W-1:0]  r_out_speed,  n_out_speed;

    logic                         in_accept;
    logic [lsp_pkg::WORD_W-1:0]   rx_word;
    logic [4:0]                   dist_pos;
    logic [7:0]                   idx_off;
    logic                         index_ok;
    logic [lsp_pkg::SLOT_W-1:0]   slot;
    logic [AW+lsp_pkg::SLOT_W-1:0] slot_ext;
    logic [AW+8:0]                angle_ext;
    logic                         slot_ok;
    logic                         angle_ok;
    logic [lsp_pkg::SUM_W-1:0]    sum;
    lsp_pkg::t_alu_ctl            alu_ctl;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [lsp_pkg::DIST_W-1:0]   ram_wdata;
    logic [lsp_pkg::DIST_W-1:0]   ram_rdata;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign rx_word   = {r_rx, r_lo};
    assign dist_pos  = r_byte_count - lsp_pkg::POS_DIST0_HI;
    assign idx_off   = r_index - lsp_pkg::INDEX_LOW;
    assign index_ok  = (r_index >= lsp_pkg::INDEX_LOW) && (r_index <= lsp_pkg::INDEX_HIGH);
    assign slot      = {idx_off[6:0], r_wcnt};
    assign slot_ext  = {{AW{1'b0}}, slot};
    assign angle_ext = {{AW{1'b0}}, r_angle};
    assign slot_ok   = 32'(slot) < ANGLE_COUNT;
    assign angle_ok  = 32'(r_angle) < ANGLE_COUNT;

    lsp_cksum u_cksum (
        .i_clk (i_clk),
        .i_ctl (alu_ctl),
        .o_sum (sum)
    );

    lsp_ram #(
        .WIDTH (lsp_pkg::DIST_W),
        .DEPTH (ANGLE_COUNT),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (angle_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_collecting = r_collecting;
        n_byte_count = r_byte_count;
        n_clr_addr   = r_clr_addr;
        n_speed      = r_speed;
        n_cmd        = r_cmd;
        n_rx         = r_rx;
        n_angle      = r_angle;
        n_lo         = r_lo;
        n_index      = r_index;
        n_speed_new  = r_speed_new;
        n_dist       = r_dist;
        n_given      = r_given;
        n_wcnt       = r_wcnt;
        n_res_status = r_res_status;
        n_res_dist   = r_res_dist;
        n_out_status = r_out_status;
        n_out_dist   = r_out_dist;
        n_out_speed  = r_out_speed;
        n_out_valid  = r_out_valid && !m_axis_tready;
        alu_ctl.op      = lsp_pkg::ALU_HOLD;
        alu_ctl.operand = rx_word;
        ram_we       = 1'b0;
        ram_waddr    = slot_ext[AW-1:0];
        ram_wdata    = r_dist[r_wcnt][lsp_pkg::DIST_W-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ANGLE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd   = s_axis_tuser;
                    n_rx    = s_axis_tdata[7:0];
                    n_angle = s_axis_tdata[16:8];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = lsp_pkg::ST_ABSORBED;
                n_res_dist   = '0;
                n_state      = S_OUT;
                if (r_cmd) begin
                    // table read address is r_angle, data arrives next cycle
                    n_state = S_READ;
                end else if (!r_collecting) begin
                    if (r_rx == lsp_pkg::START_BYTE) begin
                        n_lo         = r_rx;
                        n_byte_count = 5'd1;
                        n_collecting = 1'b1;
                        alu_ctl.op   = lsp_pkg::ALU_CLEAR;
                    end
                end else begin
                    n_byte_count = r_byte_count + 5'd1;
                    if (!r_byte_count[0]) begin
                        n_lo = r_rx;
                    end else if (r_byte_count < lsp_pkg::POS_CKSUM_LO) begin
                        alu_ctl.op = lsp_pkg::ALU_SHADD;
                        if (r_byte_count == lsp_pkg::POS_INDEX) begin
                            n_index = r_rx;
                        end
                        if (r_byte_count == lsp_pkg::POS_SPEED_HI) begin
                            n_speed_new = rx_word[lsp_pkg::WORD_W-1:6];
                        end
                        // high bytes of the four readings: 5, 9, 13, 17
                        if (r_byte_count >= lsp_pkg::POS_DIST0_HI && dist_pos[1:0] == 2'b00) begin
                            n_dist[dist_pos[3:2]] = {r_rx[7], r_rx[5:0], r_lo};
                        end
                    end else begin
                        n_given      = rx_word;
                        n_collecting = 1'b0;
                        n_byte_count = '0;
                        n_state      = S_FOLD;
                    end
                    if (r_byte_count != 5'(lsp_pkg::PACKET_BYTES - 1)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_READ: begin
                n_res_status = lsp_pkg::ST_READ_DATA;
                n_res_dist   = angle_ok ? ram_rdata : '0;
                n_state      = S_OUT;
            end
            S_FOLD: begin
                alu_ctl.op = lsp_pkg::ALU_FOLD;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                n_wcnt = '0;
                if (!index_ok) begin
                    n_res_status = lsp_pkg::ST_BAD_INDEX;
                    n_state      = S_OUT;
                end else if (r_given != {1'b0, sum}) begin
                    n_res_status = lsp_pkg::ST_BAD_CKSUM;
                    n_state      = S_OUT;
                end else begin
                    n_speed = r_speed_new;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we = !r_dist[r_wcnt][lsp_pkg::DIST_W] && slot_ok;
                n_wcnt = r_wcnt + 2'd1;
                if (r_wcnt == 2'd3) begin
                    n_res_status = lsp_pkg::ST_STORED;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_dist   = r_res_dist;
                    n_out_speed  = r_speed;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_collecting <= 1'b0;
            r_byte_count <= '0;
            r_clr_addr   <= '0;
            r_speed      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_collecting <= n_collecting;
            r_byte_count <= n_byte_count;
            r_clr_addr   <= n_clr_addr;
            r_speed      <= n_speed;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_rx         <= n_rx;
        r_angle      <= n_angle;
        r_lo         <= n_lo;
        r_index      <= n_index;
        r_speed_new  <= n_speed_new;
        r_dist       <= n_dist;
        r_given      <= n_given;
        r_wcnt       <= n_wcnt;
        r_res_status <= n_res_status;
        r_res_dist   <= n_res_dist;
        r_out_status <= n_out_status;
        r_out_dist   <= n_out_dist;
        r_out_speed  <= n_out_speed;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_speed, r_out_dist};
    assign m_axis_tuser  = r_out_status;

    `include "lidar_scan_packet_parser_defines.svh"

    `LSP_ASSERT_NOW(a_hunt_count_zero, !r_collecting, r_byte_count == 5'd0)
    `LSP_ASSERT_NOW(a_count_in_packet, r_collecting, r_byte_count < 5'(lsp_pkg::PACKET_BYTES))
    `LSP_ASSERT_NOW(a_table_write_src, ram_we, r_state == S_CLEAR || r_state == S_WRITE)
    `LSP_ASSERT_NEXT(a_accept_to_exec, in_accept, r_state == S_EXEC)

endmodule

`default_nettype wire
